@@ rtl/core/dctc_pkg.sv @@
// shared types and constants for the dram command timing checker
package dctc_pkg;

    localparam int unsigned OTHER_RANK_AGE = 1000;
    localparam int unsigned GAP_MAX        = 65535;
    localparam int unsigned ACT_WINDOW     = 4;

    typedef enum logic [2:0] {
        CMD_ACT       = 3'd0,
        CMD_READ      = 3'd1,
        CMD_READ_PRE  = 3'd2,
        CMD_WRITE     = 3'd3,
        CMD_WRITE_PRE = 3'd4,
        CMD_PRE       = 3'd5,
        CMD_OTHER     = 3'd6,
        CMD_UNUSED    = 3'd7
    } cmd_kind_t;

    typedef enum logic [1:0] {
        CFG_ACT_TIMING = 2'd0,
        CFG_COL_TIMING = 2'd1,
        CFG_RANKS      = 2'd2,
        CFG_NONE       = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_EVAL,
        ST_WRITE,
        ST_OUT
    } state_t;

    // gap = offset + signed (t - now), kept wide enough for all offsets
    function automatic logic signed [35:0] gap_of(input logic [31:0] t,
                                                  input logic signed [11:0] offset,
                                                  input logic [31:0] now);
        logic [31:0] d;
        begin
            d = t - now;
            gap_of = 36'(signed'(d)) + 36'(offset);
        end
    endfunction

    function automatic logic newer(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        begin
            d = a - b;
            newer = (d != 32'd0) && !d[31];
        end
    endfunction

endpackage

@@ rtl/core/dctc_ram.sv @@
// generic single-port synchronous ram with registered read
module dctc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/core/dram_command_timing_checker_unit.sv @@
// top level of the dram command timing checker
// One item is taken at a time. out_valid rises after the ram read, rank walk,
// evaluate and write back states; the block takes no new item until the
// result is taken and it has returned to idle, and a stall on out_ready holds
// off the next item as well. Per-bank issue times (act,
// read, write, precharge) live in one synchronous ram of RANKS*BANKS rows,
// read in one cycle and written back in another; the rank walk visits up to
// RANKS ranks in one combinational pass over small per-rank registers. Bank
// rows carry a valid bit each, cleared by reset, so unwritten rows read as
// zero and no clearing pass is needed. The activate history keeps four
// entries per rank with a saturating count. Results are held in an output
// register until taken; configuration writes are always accepted.
module dram_command_timing_checker_unit #(
    parameter int RANKS = 4,
    parameter int BANKS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [2:0]  command_kind,
    input  logic [1:0]  rank_sel,
    input  logic [2:0]  bank_sel,
    input  logic        cas_al_en,
    input  logic [31:0] now_tick,
    input  logic [7:0]  burst_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] min_gap,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import dctc_pkg::*;

    localparam int ROWS = RANKS * BANKS;
    localparam int RW   = (RANKS > 1) ? $clog2(RANKS) : 1;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    // configuration
    logic [47:0] act_cfg_reg;
    logic [63:0] col_cfg_reg;
    logic [2:0]  ranks_cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_cfg_reg   <= '0;
            col_cfg_reg   <= '0;
            ranks_cfg_reg <= 3'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ACT_TIMING: act_cfg_reg   <= cfg_data[47:0];
                CFG_COL_TIMING: col_cfg_reg   <= cfg_data;
                CFG_RANKS:      ranks_cfg_reg <= cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    // captured item
    logic        req_reg;
    cmd_kind_t   kind_reg;
    logic [RW-1:0] rank_reg;
    logic [AW-1:0] row_reg;
    logic        posted_reg;
    logic [31:0] now_reg;
    logic [7:0]  burst_reg;

    state_t state_reg, state_next;
    logic [15:0] gap_reg, gap_next;

    // bank time ram: {pre, write, read, act}
    logic [127:0] ram_rdata, ram_wdata, row_data;
    logic         ram_we;
    logic [ROWS-1:0] row_valid_reg;

    dctc_ram #(.WIDTH(128), .DEPTH(ROWS)) u_bank_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (row_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // per-rank registers
    logic [31:0] rk_rd_time_reg [RANKS];
    logic [31:0] rk_wr_time_reg [RANKS];
    logic [7:0]  rk_rd_len_reg  [RANKS];
    logic [7:0]  rk_wr_len_reg  [RANKS];
    logic [31:0] hist_reg [RANKS][ACT_WINDOW];
    logic [2:0]  hist_cnt_reg [RANKS];

    // walk results
    logic [31:0] o_rd_reg, o_wr_reg;
    logic [7:0]  o_rd_len_reg, o_wr_len_reg;
    logic [31:0] o_rd_next, o_wr_next;
    logic [7:0]  o_rd_len_next, o_wr_len_next;

    logic [2:0] walk_lim;
    assign walk_lim = (32'(ranks_cfg_reg) > RANKS) ? 3'(RANKS) : ranks_cfg_reg;

    // input decode
    logic [RW-1:0] in_rank;
    logic [AW-1:0] in_row;
    always_comb
    begin
        in_rank = RW'(32'(rank_sel) % RANKS);
        in_row  = AW'(32'(in_rank) * BANKS + 32'(bank_sel) % BANKS);
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign min_gap   = gap_reg;

    // rank walk, over the configured ranks up to RANKS, skipping the item's own rank
    always_comb
    begin
        o_rd_next     = now_reg - 32'(OTHER_RANK_AGE);
        o_wr_next     = now_reg - 32'(OTHER_RANK_AGE);
        o_rd_len_next = col_cfg_reg[23:16];
        o_wr_len_next = col_cfg_reg[23:16];
        for (int r = 0; r < RANKS; r++)
        begin
            if (r < int'(walk_lim) && RW'(r) != rank_reg)
            begin
                if (newer(rk_rd_time_reg[r], o_rd_next))
                begin
                    o_rd_next     = rk_rd_time_reg[r];
                    o_rd_len_next = rk_rd_len_reg[r];
                end
                if (newer(rk_wr_time_reg[r], o_wr_next))
                begin
                    o_wr_next     = rk_wr_time_reg[r];
                    o_wr_len_next = rk_wr_len_reg[r];
                end
            end
        end
    end

    assign row_data = row_valid_reg[row_reg] ? ram_rdata : '0;

    // gap evaluation
    logic signed [11:0] t_rp, t_rrd, t_faw, t_rcd, t_ras, t_al;
    logic signed [11:0] t_cas, t_cwd, t_burst, t_wtr, t_rtrs, t_rtp, t_wr, t_cmd;
    logic signed [11:0] rtp_extra, ord_len, owr_len;
    logic signed [35:0] g;
    logic [2:0]  cnt;
    logic [31:0] h_last;

    always_comb
    begin
        t_rp    = 12'(act_cfg_reg[7:0]);
        t_rrd   = 12'(act_cfg_reg[15:8]);
        t_faw   = 12'(act_cfg_reg[23:16]);
        t_rcd   = 12'(act_cfg_reg[31:24]);
        t_ras   = 12'(act_cfg_reg[39:32]);
        t_al    = posted_reg ? 12'(act_cfg_reg[47:40]) : 12'sd0;
        t_cas   = 12'(col_cfg_reg[7:0]);
        t_cwd   = 12'(col_cfg_reg[15:8]);
        t_burst = 12'(col_cfg_reg[23:16]);
        t_wtr   = 12'(col_cfg_reg[31:24]);
        t_rtrs  = 12'(col_cfg_reg[39:32]);
        t_rtp   = 12'(col_cfg_reg[47:40]);
        t_wr    = 12'(col_cfg_reg[55:48]);
        t_cmd   = 12'(col_cfg_reg[63:56]);
        rtp_extra = (t_rtp > t_cmd) ? t_rtp - t_cmd : 12'sd0;
        ord_len = 12'(o_rd_len_reg);
        owr_len = 12'(o_wr_len_reg);
        cnt     = hist_cnt_reg[rank_reg];
        h_last  = hist_reg[rank_reg][2'(cnt - 3'd1)];
        g = '0;
        unique case (kind_reg)
            CMD_ACT:
            begin
                g = gap_of(row_data[127:96], t_rp, now_reg);
                if (cnt != 3'd0 && gap_of(h_last, t_rrd, now_reg) > g)
                    g = gap_of(h_last, t_rrd, now_reg);
                if (cnt >= 3'(ACT_WINDOW)
                    && gap_of(hist_reg[rank_reg][0], t_faw, now_reg) > g)
                    g = gap_of(hist_reg[rank_reg][0], t_faw, now_reg);
            end
            CMD_READ, CMD_READ_PRE:
            begin
                g = gap_of(row_data[31:0], t_rcd - t_al, now_reg);
                if (gap_of(rk_rd_time_reg[rank_reg], t_burst, now_reg) > g)
                    g = gap_of(rk_rd_time_reg[rank_reg], t_burst, now_reg);
                if (gap_of(rk_wr_time_reg[rank_reg], t_cwd + t_burst + t_wtr, now_reg) > g)
                    g = gap_of(rk_wr_time_reg[rank_reg], t_cwd + t_burst + t_wtr, now_reg);
                if (ranks_cfg_reg > 3'd1)
                begin
                    if (gap_of(o_rd_reg, ord_len + t_rtrs, now_reg) > g)
                        g = gap_of(o_rd_reg, ord_len + t_rtrs, now_reg);
                    if (gap_of(o_wr_reg, t_cwd + owr_len + t_rtrs - t_cas, now_reg) > g)
                        g = gap_of(o_wr_reg, t_cwd + owr_len + t_rtrs - t_cas, now_reg);
                end
            end
            CMD_WRITE, CMD_WRITE_PRE:
            begin
                g = gap_of(row_data[31:0], t_rcd - t_al, now_reg);
                if (gap_of(rk_rd_time_reg[rank_reg], t_cas + t_burst + t_rtrs - t_cwd,
                           now_reg) > g)
                    g = gap_of(rk_rd_time_reg[rank_reg], t_cas + t_burst + t_rtrs - t_cwd,
                               now_reg);
                if (gap_of(o_rd_reg, t_cas + ord_len + t_rtrs - t_cwd, now_reg) > g)
                    g = gap_of(o_rd_reg, t_cas + ord_len + t_rtrs - t_cwd, now_reg);
                if (gap_of(rk_wr_time_reg[rank_reg], t_burst, now_reg) > g)
                    g = gap_of(rk_wr_time_reg[rank_reg], t_burst, now_reg);
                if (gap_of(o_wr_reg, owr_len, now_reg) > g)
                    g = gap_of(o_wr_reg, owr_len, now_reg);
            end
            CMD_PRE:
            begin
                g = gap_of(row_data[31:0], t_ras, now_reg);
                if (gap_of(row_data[63:32], t_al + t_cas + t_burst + rtp_extra, now_reg) > g)
                    g = gap_of(row_data[63:32], t_al + t_cas + t_burst + rtp_extra, now_reg);
                if (gap_of(row_data[95:64], t_al + t_cwd + t_burst + t_wr, now_reg) > g)
                    g = gap_of(row_data[95:64], t_al + t_cwd + t_burst + t_wr, now_reg);
            end
            default: g = '0;
        endcase
        if (36'(t_cmd) > g)
            g = 36'(t_cmd);
        if (g > 36'sd65535)
            g = 36'sd65535;
        gap_next = req_reg ? 16'd0 : g[15:0];
    end

    // write-back data for a record
    always_comb
    begin
        ram_wdata = row_data;
        ram_we    = 1'b0;
        if (state_reg == ST_WRITE && req_reg)
        begin
            unique case (kind_reg)
                CMD_ACT:                   begin ram_wdata[31:0]   = now_reg; ram_we = 1'b1; end
                CMD_READ, CMD_READ_PRE:    begin ram_wdata[63:32]  = now_reg; ram_we = 1'b1; end
                CMD_WRITE, CMD_WRITE_PRE:  begin ram_wdata[95:64]  = now_reg; ram_we = 1'b1; end
                CMD_PRE:                   begin ram_wdata[127:96] = now_reg; ram_we = 1'b1; end
                default:                   ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_WALK;
            ST_WALK:  state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_OUT;
            ST_OUT:   if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            req_reg    <= req_type;
            kind_reg   <= cmd_kind_t'(command_kind);
            rank_reg   <= in_rank;
            row_reg    <= in_row;
            posted_reg <= cas_al_en;
            now_reg    <= now_tick;
            burst_reg  <= burst_ticks;
        end
        if (state_reg == ST_WALK)
        begin
            o_rd_reg     <= o_rd_next;
            o_wr_reg     <= o_wr_next;
            o_rd_len_reg <= o_rd_len_next;
            o_wr_len_reg <= o_wr_len_next;
        end
        if (state_reg == ST_EVAL)
        begin
            gap_reg <= gap_next;
        end
        if (state_reg == ST_WRITE && req_reg && kind_reg == CMD_ACT)
        begin
            if (hist_cnt_reg[rank_reg] >= 3'(ACT_WINDOW))
            begin
                for (int i = 0; i < ACT_WINDOW - 1; i++)
                    hist_reg[rank_reg][i] <= hist_reg[rank_reg][i + 1];
                hist_reg[rank_reg][ACT_WINDOW - 1] <= now_reg;
            end
            else
            begin
                hist_reg[rank_reg][2'(hist_cnt_reg[rank_reg])] <= now_reg;
            end
        end
    end

    // per-rank state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            for (int r = 0; r < RANKS; r++)
            begin
                rk_rd_time_reg[r] <= '0;
                rk_wr_time_reg[r] <= '0;
                rk_rd_len_reg[r]  <= '0;
                rk_wr_len_reg[r]  <= '0;
                hist_cnt_reg[r]   <= '0;
            end
        end
        else if (state_reg == ST_WRITE && req_reg)
        begin
            if (ram_we)
                row_valid_reg[row_reg] <= 1'b1;
            unique case (kind_reg)
                CMD_ACT:
                begin
                    if (hist_cnt_reg[rank_reg] < 3'(ACT_WINDOW))
                        hist_cnt_reg[rank_reg] <= hist_cnt_reg[rank_reg] + 3'd1;
                end
                CMD_READ, CMD_READ_PRE:
                begin
                    rk_rd_time_reg[rank_reg] <= now_reg;
                    rk_rd_len_reg[rank_reg]  <= burst_reg;
                end
                CMD_WRITE, CMD_WRITE_PRE:
                begin
                    rk_wr_time_reg[rank_reg] <= now_reg;
                    rk_wr_len_reg[rank_reg]  <= burst_reg;
                end
                default: ;
            endcase
        end
    end
endmodule
